>>> sv/sale_pkg.sv
// Package for the sorted array list engine: item types, op and status codes, sequencer states.
`default_nettype none

package sale_pkg;

    localparam logic [2:0] OP_SORTED_INS = 3'd0;
    localparam logic [2:0] OP_HEAD_INS   = 3'd1;
    localparam logic [2:0] OP_TAIL_INS   = 3'd2;
    localparam logic [2:0] OP_DEL_FIRST  = 3'd3;
    localparam logic [2:0] OP_DEL_LAST   = 3'd4;
    localparam logic [2:0] OP_DEL_VALUE  = 3'd5;
    localparam logic [2:0] OP_REPLACE    = 3'd6;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_EMPTY     = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [6:0]         position;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] removed_value;
        logic [6:0]         count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_INS_WR,
        ST_LAST_RD,
        ST_LAST_CAP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> sv/sorted_array_list_engine_core.sv
// Sorted array list engine: bounded list in a single-port-write RAM, walked by a small sequencer.
// Replace, rejects and the unused op go straight to the result state; tail insert and any insert
// into an empty list go through the write state; delete last reads the last entry and captures it;
// delete first, delete value, sorted and head insert walk the whole list (ST_START, ST_WALK).
// One item at a time: s_ready returns as the result is registered; a result held back by m_ready
// stalls the block before it lets go.
// Reset (aresetn low, synchronous) empties the list and clears descending order; RAM is not cleared.
`default_nettype none

module sorted_array_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire sale_pkg::in_item_t  s_data,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output      sale_pkg::out_item_t m_data
);
    import sale_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int WID_W = LEN_W + 7;

    logic signed [31:0] mem [CAPACITY];

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [31:0] carry_reg, carry_next;
    logic               hit_reg, hit_next;
    logic signed [31:0] removed_reg, removed_next;
    logic [2:0]         status_reg, status_next;
    logic [2:0]         op_reg, op_next;
    logic signed [31:0] val_reg, val_next;
    logic               desc_reg;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;
    logic signed [31:0] rdata_reg;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;

    logic [LEN_W:0]     idx_plus1;
    logic               last_step;
    logic [LEN_W-1:0]   len_m1;
    logic [WID_W-1:0]   pos_ext, len_ext, pos_m1, len_wide;
    logic               moves_on, hit_now, is_full;

    assign idx_plus1 = (LEN_W+1)'(idx_reg) + (LEN_W+1)'(1);
    assign last_step = (idx_plus1 == (LEN_W+1)'(len_reg));
    assign len_m1    = len_reg - LEN_W'(1);
    assign pos_ext   = WID_W'(s_data.position);
    assign len_ext   = WID_W'(len_reg);
    assign pos_m1    = pos_ext - WID_W'(1);
    assign len_wide  = WID_W'(len_reg);
    assign is_full   = (len_reg == LEN_W'(CAPACITY));
    assign moves_on  = desc_reg ? (val_reg < rdata_reg) : (rdata_reg < val_reg);
    assign hit_now   = (op_reg == OP_DEL_FIRST) ? (idx_reg == '0) : (rdata_reg == val_reg);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            desc_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                desc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        carry_reg   <= carry_next;
        hit_reg     <= hit_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        carry_next   = carry_reg;
        hit_next     = hit_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = carry_reg;
        mem_raddr    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next      = s_data.op;
                    val_next     = s_data.value;
                    carry_next   = s_data.value;
                    removed_next = '0;
                    status_next  = STAT_OK;
                    hit_next     = 1'b0;
                    idx_next     = '0;
                    state_next   = ST_DONE;
                    case (s_data.op)
                        OP_SORTED_INS, OP_HEAD_INS, OP_TAIL_INS: begin
                            if (is_full) begin
                                status_next = STAT_FULL;
                            end else if (s_data.op == OP_TAIL_INS || len_reg == '0) begin
                                state_next = ST_INS_WR;
                            end else begin
                                hit_next   = (s_data.op == OP_HEAD_INS);
                                state_next = ST_START;
                            end
                        end
                        OP_DEL_FIRST, OP_DEL_VALUE: begin
                            if (len_reg == '0) begin
                                status_next = (s_data.op == OP_DEL_FIRST) ? STAT_EMPTY
                                                                          : STAT_NOT_FOUND;
                            end else begin
                                state_next = ST_START;
                            end
                        end
                        OP_DEL_LAST: begin
                            if (len_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                state_next = ST_LAST_RD;
                            end
                        end
                        OP_REPLACE: begin
                            if (pos_ext == '0 || pos_ext > len_ext) begin
                                status_next = STAT_BAD_INDEX;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_m1[IDX_W-1:0];
                                mem_wdata = s_data.value;
                            end
                        end
                        default: begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_START: begin
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                // rdata_reg holds entry idx_reg; fetch the next one
                mem_raddr = idx_reg + IDX_W'(1);
                idx_next  = idx_reg + IDX_W'(1);
                if (op_reg inside {OP_SORTED_INS, OP_HEAD_INS}) begin
                    // ripple insert: once placed, each entry moves up one slot
                    if (hit_reg || !moves_on) begin
                        mem_we     = 1'b1;
                        mem_waddr  = idx_reg;
                        mem_wdata  = carry_reg;
                        carry_next = rdata_reg;
                        hit_next   = 1'b1;
                    end
                    if (last_step) begin
                        state_next = ST_INS_WR;
                    end
                end else begin
                    if (hit_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg - IDX_W'(1);
                        mem_wdata = rdata_reg;
                    end else if (hit_now) begin
                        hit_next = 1'b1;
                        if (op_reg == OP_DEL_FIRST) begin
                            removed_next = rdata_reg;
                        end
                    end
                    if (last_step) begin
                        state_next = ST_DONE;
                        if (hit_next) begin
                            len_next = len_m1;
                        end else begin
                            status_next = STAT_NOT_FOUND;
                        end
                    end
                end
            end
            ST_INS_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = len_reg[IDX_W-1:0];
                mem_wdata  = carry_reg;
                len_next   = len_reg + LEN_W'(1);
                state_next = ST_DONE;
            end
            ST_LAST_RD: begin
                mem_raddr  = len_m1[IDX_W-1:0];
                state_next = ST_LAST_CAP;
            end
            ST_LAST_CAP: begin
                removed_next = rdata_reg;
                len_next     = len_m1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = status_reg;
                    m_data_next.removed_value = removed_reg;
                    m_data_next.count         = len_wide[6:0];
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_ins_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INS_WR |=> len_reg == $past(len_reg) + LEN_W'(1))
        else $error("insert did not grow the list by one");

    a_shift_down_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && hit_reg && mem_we &&
         !(op_reg == OP_SORTED_INS || op_reg == OP_HEAD_INS)) |-> idx_reg != '0)
        else $error("remove shift below entry zero");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && status_reg == STAT_FULL) |-> is_full)
        else $error("full status with room in the list");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Testbench for the sorted array list engine: directed table, random phases, queue-based checker.
`timescale 1ns / 1ps

module testbench;
    import sale_pkg::*;

    localparam int         LIST_CAP       = 64;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         TAIL_CYCLES    = 100;
    localparam int         N_DIRECTED     = 25;
    localparam int         N_PHASES       = 7;
    localparam logic [2:0] OP_UNUSED      = 3'd7;

    localparam int   PHASE_GROW  [N_PHASES] = '{90, 50, 10, 55, 85, 15, 50};
    localparam int   PHASE_ITEMS [N_PHASES] = '{150, 250, 150, 300, 150, 150, 400};
    localparam logic PHASE_DESC  [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    localparam logic PHASE_IDLE  [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

    typedef struct packed {
        in_item_t  stim;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      s_valid   = 1'b0;
    in_item_t  s_data    = '0;
    logic      m_ready   = 1'b0;
    logic      s_ready;
    logic      m_valid;
    out_item_t m_data;

    logic signed [31:0] list_copy [0:LIST_CAP-1];
    int                 list_len   = 0;
    logic               descending = 1'b0;

    out_item_t pending_results [$];
    dir_row_t  dir_tab [N_DIRECTED];

    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    int n_mismatch  = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_full      = 0;
    int max_len     = 0;
    int idle_cycles = 0;

    sorted_array_list_engine_core #(
        .CAPACITY (LIST_CAP)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow list: applies one op and returns the result it should give
    function automatic out_item_t predict_list_op(in_item_t op_item);
        out_item_t res;
        int        slot;
        int        k;
        res  = '0;
        slot = 0;
        res.status = STAT_OK;
        case (op_item.op)
            OP_SORTED_INS, OP_HEAD_INS, OP_TAIL_INS: begin
                if (list_len >= LIST_CAP) begin
                    res.status = STAT_FULL;
                end else begin
                    if (op_item.op == OP_TAIL_INS) begin
                        slot = list_len;
                    end else if (op_item.op == OP_SORTED_INS) begin
                        while (slot < list_len && (descending
                                ? $signed(op_item.value) < $signed(list_copy[slot])
                                : $signed(list_copy[slot]) < $signed(op_item.value)))
                            slot++;
                    end
                    for (k = list_len; k > slot; k--)
                        list_copy[k] = list_copy[k-1];
                    list_copy[slot] = op_item.value;
                    list_len++;
                end
            end
            OP_DEL_FIRST: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.removed_value = list_copy[0];
                    for (k = 0; k < list_len - 1; k++)
                        list_copy[k] = list_copy[k+1];
                    list_len--;
                end
            end
            OP_DEL_LAST: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.removed_value = list_copy[list_len-1];
                    list_len--;
                end
            end
            OP_DEL_VALUE: begin
                while (slot < list_len && list_copy[slot] != op_item.value)
                    slot++;
                if (slot == list_len) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    for (k = slot; k < list_len - 1; k++)
                        list_copy[k] = list_copy[k+1];
                    list_len--;
                end
            end
            OP_REPLACE: begin
                if (op_item.position < 1 || op_item.position > list_len)
                    res.status = STAT_BAD_INDEX;
                else
                    list_copy[op_item.position-1] = op_item.value;
            end
            default: ;
        endcase
        res.count = 7'(list_len);
        return res;
    endfunction

    function automatic in_item_t random_item(int grow_pct);
        in_item_t op_item;
        int       pick;
        pick = $urandom_range(99);
        if (pick < grow_pct)
            op_item.op = 3'($urandom_range(OP_TAIL_INS, OP_SORTED_INS));
        else if (pick < 98)
            op_item.op = 3'($urandom_range(OP_REPLACE, OP_DEL_FIRST));
        else
            op_item.op = OP_UNUSED;

        case ($urandom_range(9))
            0:       op_item.value = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1:       op_item.value = $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            2, 3, 4: op_item.value = $signed(32'($urandom_range(15))) - 32'sd8;
            5, 6:    op_item.value = (list_len > 0)
                                     ? list_copy[$urandom_range(list_len - 1)] : $urandom;
            default: op_item.value = $urandom;
        endcase
        if (op_item.op == OP_DEL_VALUE && list_len > 0 && $urandom_range(1))
            op_item.value = list_copy[$urandom_range(list_len - 1)];

        case ($urandom_range(9))
            0:       op_item.position = 7'd0;
            1:       op_item.position = 7'(list_len + 1);
            2, 3:    op_item.position = 7'($urandom_range(127));
            default: op_item.position = (list_len > 0)
                                        ? 7'($urandom_range(list_len, 1))
                                        : 7'($urandom_range(127));
        endcase
        return op_item;
    endfunction

    function automatic dir_row_t dir_row(logic [2:0] op, logic [31:0] value, logic [6:0] pos,
                                         logic typed = 1'b0, logic [2:0] st = STAT_OK,
                                         logic [6:0] cnt = 7'd0);
        dir_row_t r;
        r.stim.op           = op;
        r.stim.value        = value;
        r.stim.position     = pos;
        r.typed             = typed;
        r.want.status       = st;
        r.want.removed_value = '0;
        r.want.count        = cnt;
        return r;
    endfunction

    task automatic send_item(input in_item_t op_item, input logic typed, input out_item_t want);
        out_item_t pred;
        if (tx_idle_on && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op_item;
        do @(posedge aclk); while (!s_ready);
        pred = predict_list_op(op_item);
        pending_results.push_back(typed ? want : pred);
        n_items++;
        if (pred.status == STAT_FULL)
            n_full++;
        if (list_len > max_len)
            max_len = list_len;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_order(input logic desc);
        cfg_we    <= 1'b1;
        cfg_wdata <= desc;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        descending = desc;
    endtask

    always @(posedge aclk)
        m_ready <= !(rx_idle_on && ($urandom_range(99) < 7));

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, actual status %0d removed %0d count %0d",
                         $time, m_data.status, m_data.removed_value, m_data.count);
                n_mismatch++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_data.status);
                    n_mismatch++;
                end
                if (m_data.removed_value !== want.removed_value) begin
                    $display("%0t: removed_value mismatch, expected %0d, actual %0d",
                             $time, want.removed_value, m_data.removed_value);
                    n_mismatch++;
                end
                if (m_data.count !== want.count) begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, want.count, m_data.count);
                    n_mismatch++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int p;
        int n;
        dir_tab = '{
            dir_row(OP_DEL_FIRST,  32'd0,         7'd0,   1'b1, STAT_EMPTY,     7'd0),
            dir_row(OP_DEL_LAST,   32'd0,         7'd0,   1'b1, STAT_EMPTY,     7'd0),
            dir_row(OP_DEL_VALUE,  32'd5,         7'd0,   1'b1, STAT_NOT_FOUND, 7'd0),
            dir_row(OP_REPLACE,    32'd9,         7'd1,   1'b1, STAT_BAD_INDEX, 7'd0),
            dir_row(OP_UNUSED,     32'h7FFF_FFFF, 7'd127, 1'b1, STAT_OK,        7'd0),
            dir_row(OP_SORTED_INS, 32'h7FFF_FFFF, 7'd0,   1'b1, STAT_OK,        7'd1),
            dir_row(OP_SORTED_INS, 32'h8000_0000, 7'd0,   1'b1, STAT_OK,        7'd2),
            dir_row(OP_SORTED_INS, 32'd0,         7'd0),
            dir_row(OP_SORTED_INS, 32'd0,         7'd0),
            dir_row(OP_HEAD_INS,   32'hFFFF_FFFF, 7'd0),
            dir_row(OP_TAIL_INS,   32'd1,         7'd0),
            dir_row(OP_REPLACE,    32'd3,         7'd0,   1'b1, STAT_BAD_INDEX, 7'd6),
            dir_row(OP_REPLACE,    32'd3,         7'd7,   1'b1, STAT_BAD_INDEX, 7'd6),
            dir_row(OP_REPLACE,    32'd3,         7'd127, 1'b1, STAT_BAD_INDEX, 7'd6),
            dir_row(OP_REPLACE,    32'h5555_5555, 7'd6,   1'b1, STAT_OK,        7'd6),
            dir_row(OP_REPLACE,    32'hAAAA_AAAA, 7'd1,   1'b1, STAT_OK,        7'd6),
            dir_row(OP_DEL_VALUE,  32'd0,         7'd0),
            dir_row(OP_DEL_VALUE,  32'd12345,     7'd0,   1'b1, STAT_NOT_FOUND, 7'd5),
            dir_row(OP_DEL_FIRST,  32'd0,         7'd0),
            dir_row(OP_DEL_LAST,   32'd0,         7'd0),
            dir_row(OP_DEL_VALUE,  32'h7FFF_FFFF, 7'd0),
            dir_row(OP_SORTED_INS, 32'h8000_0000, 7'd0),
            dir_row(OP_DEL_FIRST,  32'd0,         7'd0),
            dir_row(OP_DEL_FIRST,  32'd0,         7'd0),
            dir_row(OP_DEL_LAST,   32'd0,         7'd0)
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_order(1'b0);

        for (n = 0; n < N_DIRECTED; n++)
            send_item(dir_tab[n].stim, dir_tab[n].typed, dir_tab[n].want);

        for (p = 0; p < N_PHASES; p++) begin
            drain_results();
            write_order(PHASE_DESC[p]);
            tx_idle_on = PHASE_IDLE[p];
            rx_idle_on = PHASE_IDLE[p];
            for (n = 0; n < PHASE_ITEMS[p]; n++)
                send_item(random_item(PHASE_GROW[p]), 1'b0, '0);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d items (%0d results) over %0d random phases in both sort orders;",
                 n_items, n_results, N_PHASES);
        $display("list depth reached %0d, %0d inserts refused on a full list.", max_len, n_full);
        if (n_mismatch == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
